@@ design/seen_mac_table_assert.svh @@
// ----------------------------------------------------------------------------
// seen_mac_table_assert.svh
// Assertion macros used by the seen-address table RTL.
// ----------------------------------------------------------------------------
`ifndef SEEN_MAC_TABLE_ASSERT_SVH
`define SEEN_MAC_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SMT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg
// Types and constants for the seen-address table.
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int KEY_W = 48;

    typedef logic [KEY_W-1:0] t_key;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_INSERT
    } t_state;

endpackage

@@ design/seen_mac_table.sv @@
// ----------------------------------------------------------------------------
// seen_mac_table
// Table of already-seen 48-bit addresses, searched entry by entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_mac_addr and raise start; the transaction is taken
//   at a rising edge where start is high and busy is low. busy then stays
//   high until the answer is ready.
//   Output channel: o_valid pulses for one cycle with o_was_known and
//   o_table_cleared. There is no back-pressure; the receiver must take the
//   result in that cycle.
//   Search: one key memory read per cycle through a single comparator. A hit
//   answers once its entry has been compared; a miss compares every filled
//   entry (none when the table is empty) and then inserts the address.
//   The next transaction may be taken in the strobe cycle.
//   A miss appends the address at the fill count; when the count reaches
//   TABLE_ENTRIES it returns to zero and o_table_cleared is set.
//   Reset: synchronous, active low; clears the fill count and control state.
//   Memory contents are not cleared: only entries below the fill count are
//   ever compared, and all of those were written since the last wrap.
// ----------------------------------------------------------------------------
module seen_mac_table #(
    parameter int TABLE_ENTRIES = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  smt_pkg::t_key  i_mac_addr,
    output logic           o_valid,
    output logic           o_was_known,
    output logic           o_table_cleared
);
    import smt_pkg::*;

    `include "seen_mac_table_assert.svh"

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_fill, n_fill;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_pend, n_pend;
    logic             r_pend_last, n_pend_last;
    t_key             r_key, n_key;
    logic             r_valid, n_valid;
    logic             r_known, n_known;
    logic             r_cleared, n_cleared;

    logic             wr_en;
    t_key             rd_data;
    logic             accept;
    logic             key_match;

    assign accept    = start && (r_state == S_IDLE);
    assign key_match = (rd_data == r_key);

    // Key store: one read per cycle during the search, one write on insert.
    smt_key_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill),
        .i_wr_data (r_key),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pend_last <= n_pend_last;
        r_key       <= n_key;
        r_known     <= n_known;
        r_cleared   <= n_cleared;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = r_pend_last;
        n_key       = r_key;
        n_valid     = 1'b0;
        n_known     = r_known;
        n_cleared   = r_cleared;
        wr_en       = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    // Latch the address; skip the search on an empty table.
                    n_key = i_mac_addr;
                    n_idx = '0;
                    if (r_fill == '0) begin
                        n_state = S_INSERT;
                    end else begin
                        n_state = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // Issue the read of r_idx; compare the data read last cycle.
                n_pend      = 1'b1;
                n_pend_last = (r_idx == r_fill - IDX_W'(1));
                n_idx       = r_idx + IDX_W'(1);
                if (r_pend && key_match) begin
                    n_state   = S_IDLE;
                    n_pend    = 1'b0;
                    n_valid   = 1'b1;
                    n_known   = 1'b1;
                    n_cleared = 1'b0;
                end else if (r_pend && r_pend_last) begin
                    n_state = S_INSERT;
                    n_pend  = 1'b0;
                end
            end
            S_INSERT: begin
                // Append at the fill count; wrap to zero when the table fills.
                wr_en     = 1'b1;
                n_state   = S_IDLE;
                n_valid   = 1'b1;
                n_known   = 1'b0;
                n_cleared = (r_fill == LAST_IDX);
                n_fill    = (r_fill == LAST_IDX) ? '0 : r_fill + IDX_W'(1);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != S_IDLE);
    assign o_valid         = r_valid;
    assign o_was_known     = r_known;
    assign o_table_cleared = r_cleared;

    `SMT_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy,
        "accepted transaction did not raise busy")
    `SMT_ASSERT_NXT(a_empty_insert, i_clk, i_rst_n, accept && (r_fill == '0),
        r_state == S_INSERT, "empty table did not go straight to insert")
    `SMT_ASSERT_IMP(a_known_no_clear, i_clk, i_rst_n, o_valid,
        !(o_was_known && o_table_cleared), "hit reported together with a wrap")
    `SMT_ASSERT_IMP(a_clear_fill_zero, i_clk, i_rst_n, o_valid && o_table_cleared,
        r_fill == '0, "wrap reported but fill count not zero")
    `SMT_ASSERT_NXT(a_insert_strobe, i_clk, i_rst_n, r_state == S_INSERT,
        o_valid && !o_was_known, "insert did not produce a miss result")

endmodule

@@ design/smt_key_ram.sv @@
// ----------------------------------------------------------------------------
// smt_key_ram
// Single-port-write, single-port-read key memory with registered read data.
// ----------------------------------------------------------------------------
module smt_key_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  smt_pkg::t_key   i_wr_data,
    input  logic [AW-1:0]   i_rd_addr,
    output smt_pkg::t_key   o_rd_data
);
    import smt_pkg::*;

    t_key r_mem [DEPTH];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
